FILE: rtl/pimsa_pkg.sv
// pimsa_pkg: shared types, codes and defaults for the PIM subarray block.
// No dependencies; imported by every module of the block except pimsa_ram.
package pimsa_pkg;

  localparam int DEF_NUM_ROWS        = 64;
  localparam int DEF_NUM_COLS        = 64;
  localparam int DEF_MAX_ACTIVE_ROWS = 3;
  localparam int DATA_W              = 64;
  localparam int IDX_W               = 8;

  typedef enum logic [2:0] {
    OP_READ_ROW    = 3'd0,
    OP_WRITE_ROW   = 3'd1,
    OP_READ_COL    = 3'd2,
    OP_WRITE_COL   = 3'd3,
    OP_ACTIVATE    = 3'd4,
    OP_MULTI_WRITE = 3'd5,
    OP_SET_ROW     = 3'd6,
    OP_SET_COL     = 3'd7
  } pimsa_op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_ROW_RANGE = 2'd1,
    STS_COL_RANGE = 2'd2,
    STS_ROW_COUNT = 2'd3
  } pimsa_status_e;

  typedef struct packed {
    pimsa_op_e         operation;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [IDX_W-1:0]  index_c;
    logic              negate_a;
    logic              negate_b;
    logic              negate_c;
    logic [1:0]        row_count;
    logic [DATA_W-1:0] load_bits;
  } pimsa_in_t;

  typedef struct packed {
    pimsa_status_e     status;
    logic [DATA_W-1:0] row_sense_bits;
    logic [DATA_W-1:0] col_sense_bits;
  } pimsa_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic wr_en;
    logic maj;
    logic load_sense;
    logic out_load;
  } pimsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    pimsa_op_e     op;
    logic [1:0]    count;
    pimsa_status_e err;
  } pimsa_stat_t;

endpackage

FILE: rtl/pimsa_ram.sv
// pimsa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pimsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/pimsa_ctrl.sv
// pimsa_ctrl: sequencer for the PIM subarray; issues read/write/majority steps.
// Depends on pimsa_pkg.
module pimsa_ctrl import pimsa_pkg::*; #(
  parameter int NUM_ROWS = DEF_NUM_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  pimsa_stat_t                 stat_i,
  output pimsa_cmd_t                  cmd_o,
  output logic [$clog2(NUM_ROWS)-1:0] step_o
);

  localparam int ROW_W = $clog2(NUM_ROWS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_MAJ   = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic [ROW_W-1:0] rd_last, wr_last, cnt_last;

  assign cnt_last = ROW_W'(stat_i.count - 2'd1);

  always_comb begin
    rd_last = '0;
    if (stat_i.op == OP_READ_COL || stat_i.op == OP_WRITE_COL) begin
      rd_last = ROW_W'(NUM_ROWS - 1);
    end else if (stat_i.op == OP_ACTIVATE) begin
      rd_last = cnt_last;
    end
    wr_last = '0;
    if (stat_i.op == OP_ACTIVATE || stat_i.op == OP_MULTI_WRITE) begin
      wr_last = cnt_last;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        step_d = '0;
        if (stat_i.err != STS_OK) begin
          state_d = ST_DONE;
        end else begin
          unique case (stat_i.op)
            OP_READ_ROW, OP_READ_COL, OP_WRITE_COL, OP_ACTIVATE: state_d = ST_READ;
            OP_WRITE_ROW: state_d = ST_WRITE;
            OP_MULTI_WRITE: state_d = (stat_i.count == 2'd0) ? ST_DONE : ST_WRITE;
            OP_SET_ROW, OP_SET_COL: begin
              cmd_o.load_sense = 1'b1;
              state_d          = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        if (step_q == rd_last) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        step_d  = '0;
        state_d = (stat_i.op == OP_ACTIVATE) ? ST_MAJ : ST_DONE;
      end
      ST_MAJ: begin
        cmd_o.maj = 1'b1;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (step_q == wr_last) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign step_o      = step_q;

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CHECK)
    else $error("accepted beat not followed by check");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result dropped");

  a_write_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> step_q <= ROW_W'(2))
    else $error("multi-row write step out of range");

endmodule

FILE: rtl/pimsa_dpath.sv
// pimsa_dpath: cell array, sense registers, majority logic and result register.
// Depends on pimsa_pkg and pimsa_ram.
module pimsa_dpath import pimsa_pkg::*; #(
  parameter int NUM_ROWS        = DEF_NUM_ROWS,
  parameter int NUM_COLS        = DEF_NUM_COLS,
  parameter int MAX_ACTIVE_ROWS = DEF_MAX_ACTIVE_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pimsa_in_t                   in_i,
  input  pimsa_cmd_t                  cmd_i,
  input  logic [$clog2(NUM_ROWS)-1:0] step_i,
  output pimsa_stat_t                 stat_o,
  output pimsa_out_t                  out_o
);

  localparam int ROW_W = $clog2(NUM_ROWS);
  localparam int COL_W = $clog2(NUM_COLS);

  pimsa_in_t             item_q;
  logic [NUM_COLS-1:0]   row_sense_q;
  logic [NUM_ROWS-1:0]   col_sense_q;
  logic [NUM_COLS-1:0]   v_q [3];
  logic [NUM_ROWS-1:0]   vld_q;
  logic                  rd_pend_q;
  logic [ROW_W-1:0]      rd_step_q;
  logic                  rd_vld_q;
  pimsa_out_t            out_q;

  logic [IDX_W-1:0]      idx [3];
  logic [2:0]            neg;
  logic [2:0]            row_bad;
  logic                  col_bad, count_bad, multi_bad;
  pimsa_status_e         err;
  logic [COL_W-1:0]      col_idx;
  logic                  col_op, wb_en;
  logic [ROW_W-1:0]      rd_addr, wr_addr;
  logic [NUM_COLS-1:0]   ram_rdata, rdata, wb_data, wr_data, maj;
  logic                  wr_en;

  assign idx[0]  = item_q.index_a;
  assign idx[1]  = item_q.index_b;
  assign idx[2]  = item_q.index_c;
  assign neg     = {item_q.negate_c, item_q.negate_b, item_q.negate_a};
  assign col_idx = item_q.index_a[COL_W-1:0];
  assign col_op  = item_q.operation == OP_READ_COL || item_q.operation == OP_WRITE_COL;

  // error decode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_bad[i] = idx[i] >= IDX_W'(NUM_ROWS);
    end
    col_bad   = item_q.index_a >= IDX_W'(NUM_COLS);
    count_bad = item_q.row_count > 2'(MAX_ACTIVE_ROWS) ||
                (item_q.operation == OP_ACTIVATE && !item_q.row_count[0]);
    multi_bad = (item_q.row_count >= 2'd1 && row_bad[0]) ||
                (item_q.row_count >= 2'd2 && row_bad[1]) ||
                (item_q.row_count == 2'd3 && row_bad[2]);
    unique case (item_q.operation)
      OP_READ_ROW, OP_WRITE_ROW: err = row_bad[0] ? STS_ROW_RANGE : STS_OK;
      OP_READ_COL, OP_WRITE_COL: err = col_bad ? STS_COL_RANGE : STS_OK;
      OP_ACTIVATE, OP_MULTI_WRITE: begin
        err = count_bad ? STS_ROW_COUNT : (multi_bad ? STS_ROW_RANGE : STS_OK);
      end
      default: err = STS_OK;
    endcase
  end

  assign stat_o.op    = item_q.operation;
  assign stat_o.count = item_q.row_count;
  assign stat_o.err   = err;

  // array access
  assign rd_addr = col_op ? step_i : idx[step_i[1:0]][ROW_W-1:0];
  assign rdata   = rd_vld_q ? ram_rdata : '0;
  assign wb_en   = rd_pend_q && item_q.operation == OP_WRITE_COL;
  assign wr_en   = cmd_i.wr_en || wb_en;

  always_comb begin
    wb_data          = rdata;
    wb_data[col_idx] = col_sense_q[rd_step_q];
    if (wb_en) begin
      wr_addr = rd_step_q;
      wr_data = wb_data;
    end else begin
      wr_addr = idx[step_i[1:0]][ROW_W-1:0];
      if (item_q.operation == OP_WRITE_ROW) begin
        wr_data = row_sense_q;
      end else begin
        wr_data = neg[step_i[1:0]] ? ~row_sense_q : row_sense_q;
      end
    end
  end

  assign maj = (item_q.row_count == 2'd1) ? v_q[0] :
               (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);

  pimsa_ram #(
    .WIDTH (NUM_COLS),
    .DEPTH (NUM_ROWS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sense_q <= '0;
      col_sense_q <= '0;
      vld_q       <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_pend_q && item_q.operation == OP_READ_ROW) begin
        row_sense_q <= rdata;
      end else if (cmd_i.maj) begin
        row_sense_q <= maj;
      end else if (cmd_i.load_sense && item_q.operation == OP_SET_ROW) begin
        row_sense_q <= item_q.load_bits[NUM_COLS-1:0];
      end
      if (rd_pend_q && item_q.operation == OP_READ_COL) begin
        col_sense_q[rd_step_q] <= rdata[col_idx];
      end else if (cmd_i.load_sense && item_q.operation == OP_SET_COL) begin
        col_sense_q <= item_q.load_bits[NUM_ROWS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_i;
    end
    if (cmd_i.rd_en) begin
      rd_step_q <= step_i;
      rd_vld_q  <= vld_q[rd_addr];
    end
    if (rd_pend_q && item_q.operation == OP_ACTIVATE) begin
      v_q[rd_step_q[1:0]] <= rdata ^ {NUM_COLS{neg[rd_step_q[1:0]]}};
    end
    if (cmd_i.out_load) begin
      out_q.status         <= err;
      out_q.row_sense_bits <= DATA_W'(row_sense_q);
      out_q.col_sense_bits <= DATA_W'(col_sense_q);
    end
  end

  assign out_o = out_q;

  a_wb_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wb_en && cmd_i.wr_en))
    else $error("column write-back collides with row write");

endmodule

FILE: rtl/pim_subarray_majority_rows_top.sv
// Column read/write steps through the cell array one row a cycle.
// One item in flight: a new beat is accepted only after the last one is done; the
//   single-port-read cell array paces the array ops. A result waiting in the output
//   register does not block the next accept. Reset clears the sense regs and the row
//   valid bits, so the array reads as zero.
// Depends on pimsa_pkg, pimsa_ctrl, pimsa_dpath.
module pim_subarray_majority_rows_top import pimsa_pkg::*; #(
  parameter int NUM_ROWS        = DEF_NUM_ROWS,
  parameter int NUM_COLS        = DEF_NUM_COLS,
  parameter int MAX_ACTIVE_ROWS = DEF_MAX_ACTIVE_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pimsa_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pimsa_out_t out_data_o
);

  pimsa_cmd_t                  cmd;
  pimsa_stat_t                 stat;
  logic [$clog2(NUM_ROWS)-1:0] step;

  pimsa_ctrl #(
    .NUM_ROWS (NUM_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .step_o      (step)
  );

  pimsa_dpath #(
    .NUM_ROWS        (NUM_ROWS),
    .NUM_COLS        (NUM_COLS),
    .MAX_ACTIVE_ROWS (MAX_ACTIVE_ROWS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .step_i (step),
    .stat_o (stat),
    .out_o  (out_data_o)
  );

endmodule

FILE: sim/pim_subarray_majority_rows_top_test.sv
// Self-checking testbench for pim_subarray_majority_rows_top: queue-fed driver, clocked monitor,
// built-in predictor of the cell array and both sense registers; directed then random beats.
// Depends on pimsa_pkg and the RTL of pim_subarray_majority_rows_top.
module pim_subarray_majority_rows_top_test;
  import pimsa_pkg::*;

  localparam int ROWS       = DEF_NUM_ROWS;
  localparam int COLS       = DEF_NUM_COLS;
  localparam int MAX_ACT    = DEF_MAX_ACTIVE_ROWS;
  localparam int N_RANDOM   = 1000;
  localparam int PHASE_LEN  = 120;
  localparam int DRAIN_CYC  = 2 * (ROWS + 8);
  localparam int IDLE_LIMIT = 20000;
  localparam logic [DATA_W-1:0] COL_MASK = (COLS >= DATA_W) ? '1 : ((64'd1 << COLS) - 64'd1);
  localparam logic [DATA_W-1:0] ROW_MASK = (ROWS >= DATA_W) ? '1 : ((64'd1 << ROWS) - 64'd1);

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  pimsa_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pimsa_out_t out_data_o;

  pim_subarray_majority_rows_top #(
    .NUM_ROWS       (ROWS),
    .NUM_COLS       (COLS),
    .MAX_ACTIVE_ROWS(MAX_ACT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [DATA_W-1:0] cells_model [ROWS];
  logic [DATA_W-1:0] row_sense_model;
  logic [DATA_W-1:0] col_sense_model;

  pimsa_in_t  pending_items [$];
  pimsa_out_t expected_results [$];
  int         beats_in = 0;
  int         beats_issued = 0;
  int         error_count = 0;
  int         idle_cycles = 0;
  int         phase;

  assign phase = (beats_in / PHASE_LEN) % 4;

  function automatic pimsa_out_t predict_subarray(pimsa_in_t it);
    pimsa_out_t        res;
    pimsa_status_e     sts;
    logic [IDX_W-1:0]  idx [3];
    logic              neg [3];
    logic [DATA_W-1:0] rd [3];
    logic [DATA_W-1:0] col_bits;
    logic [DATA_W-1:0] maj;
    int                cnt;
    idx[0] = it.index_a;
    idx[1] = it.index_b;
    idx[2] = it.index_c;
    neg[0] = it.negate_a;
    neg[1] = it.negate_b;
    neg[2] = it.negate_c;
    cnt = it.row_count;
    sts = STS_OK;
    case (it.operation)
      OP_READ_ROW: begin
        if (idx[0] >= ROWS) sts = STS_ROW_RANGE;
        else row_sense_model = cells_model[idx[0]] & COL_MASK;
      end
      OP_WRITE_ROW: begin
        if (idx[0] >= ROWS) sts = STS_ROW_RANGE;
        else cells_model[idx[0]] = row_sense_model & COL_MASK;
      end
      OP_READ_COL: begin
        if (idx[0] >= COLS) begin
          sts = STS_COL_RANGE;
        end else begin
          col_bits = '0;
          for (int r = 0; r < ROWS; r++) col_bits[r] = cells_model[r][idx[0]];
          col_sense_model = col_bits & ROW_MASK;
        end
      end
      OP_WRITE_COL: begin
        if (idx[0] >= COLS) sts = STS_COL_RANGE;
        else for (int r = 0; r < ROWS; r++) cells_model[r][idx[0]] = col_sense_model[r];
      end
      OP_ACTIVATE, OP_MULTI_WRITE: begin
        if (cnt > MAX_ACT || (it.operation == OP_ACTIVATE && (cnt % 2) == 0)) begin
          sts = STS_ROW_COUNT;
        end else begin
          for (int i = 0; i < cnt; i++) if (idx[i] >= ROWS) sts = STS_ROW_RANGE;
        end
        if (sts == STS_OK) begin
          if (it.operation == OP_ACTIVATE) begin
            for (int i = 0; i < 3; i++) rd[i] = '0;
            for (int i = 0; i < cnt; i++)
              rd[i] = (neg[i] ? ~cells_model[idx[i]] : cells_model[idx[i]]) & COL_MASK;
            if (cnt == 1) maj = rd[0];
            else maj = (rd[0] & rd[1]) | (rd[0] & rd[2]) | (rd[1] & rd[2]);
            row_sense_model = maj & COL_MASK;
          end
          for (int i = 0; i < cnt; i++)
            cells_model[idx[i]] = (neg[i] ? ~row_sense_model : row_sense_model) & COL_MASK;
        end
      end
      OP_SET_ROW: row_sense_model = it.load_bits & COL_MASK;
      default:    col_sense_model = it.load_bits & ROW_MASK;
    endcase
    res.status         = sts;
    res.row_sense_bits = row_sense_model;
    res.col_sense_bits = col_sense_model;
    return res;
  endfunction

  function automatic pimsa_in_t make_item(pimsa_op_e op, int a, int b, int c,
                                          bit na, bit nb, bit nc, int cnt,
                                          logic [DATA_W-1:0] bits);
    pimsa_in_t it;
    it.operation = op;
    it.index_a   = IDX_W'(a);
    it.index_b   = IDX_W'(b);
    it.index_c   = IDX_W'(c);
    it.negate_a  = na;
    it.negate_b  = nb;
    it.negate_c  = nc;
    it.row_count = 2'(cnt);
    it.load_bits = bits;
    return it;
  endfunction

  function automatic pimsa_in_t make_random_item();
    pimsa_in_t it;
    int        roll;
    it.operation = pimsa_op_e'(3'($urandom_range(7)));
    it.index_a   = IDX_W'($urandom_range(255));
    it.index_b   = IDX_W'($urandom_range(255));
    it.index_c   = IDX_W'($urandom_range(255));
    it.negate_a  = 1'($urandom_range(1));
    it.negate_b  = 1'($urandom_range(1));
    it.negate_c  = 1'($urandom_range(1));
    it.row_count = 2'($urandom_range(3));
    it.load_bits = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 5) it.load_bits = '1;
    else if (roll < 10) it.load_bits = '0;
    else if (roll < 15) it.load_bits = 64'd1 << $urandom_range(63);
    if ($urandom_range(99) < 85) begin
      if (it.operation == OP_READ_COL || it.operation == OP_WRITE_COL) begin
        it.index_a = IDX_W'($urandom_range(COLS - 1));
      end else begin
        it.index_a = IDX_W'($urandom_range(ROWS - 1));
        it.index_b = IDX_W'($urandom_range(ROWS - 1));
        it.index_c = IDX_W'($urandom_range(ROWS - 1));
      end
      if (it.operation == OP_ACTIVATE) it.row_count = ($urandom_range(99) < 70) ? 2'd3 : 2'd1;
      roll = $urandom_range(99);
      if (roll < 10) it.index_b = it.index_a;
      else if (roll < 15) it.index_c = it.index_b;
    end
    return it;
  endfunction

  // driver: new beats at the falling edge, held until accepted
  always @(negedge clk_i) begin
    pimsa_in_t nxt;
    int        idle_pct;
    int        stall_pct;
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 55; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 55; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
    if (rst_ni) begin
      if (!(in_valid_i && beats_issued != beats_in)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_items.pop_front();
          in_data_i <= nxt;
          in_valid_i <= 1'b1;
          beats_issued++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and predictor update at the rising edge
  always @(posedge clk_i) begin
    pimsa_out_t exp_res;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(predict_subarray(in_data_i));
      beats_in++;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat status %0d row %h col %h", $time,
                 out_data_o.status, out_data_o.row_sense_bits, out_data_o.col_sense_bits);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.status !== exp_res.status) begin
          $display("%0t status mismatch exp %0d act %0d", $time,
                   exp_res.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.row_sense_bits !== exp_res.row_sense_bits) begin
          $display("%0t row sense mismatch exp %h act %h", $time,
                   exp_res.row_sense_bits, out_data_o.row_sense_bits);
          error_count++;
        end
        if (out_data_o.col_sense_bits !== exp_res.col_sense_bits) begin
          $display("%0t col sense mismatch exp %h act %h", $time,
                   exp_res.col_sense_bits, out_data_o.col_sense_bits);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < ROWS; r++) cells_model[r] = '0;
    row_sense_model = '0;
    col_sense_model = '0;

    // directed: range edges, every op, count checks, duplicates
    pending_items.push_back(make_item(OP_READ_ROW, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_SET_ROW, 0, 0, 0, 0, 0, 0, 0, '1));
    pending_items.push_back(make_item(OP_WRITE_ROW, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_WRITE_ROW, ROWS - 1, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_WRITE_ROW, ROWS, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_READ_ROW, 255, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_SET_ROW, 0, 0, 0, 0, 0, 0, 0, 64'h0123_4567_89ab_cdef));
    pending_items.push_back(make_item(OP_WRITE_ROW, 5, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_READ_ROW, ROWS - 1, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_SET_COL, 0, 0, 0, 0, 0, 0, 0, 64'hf0f0_5555_aaaa_0f0f));
    pending_items.push_back(make_item(OP_WRITE_COL, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_WRITE_COL, COLS - 1, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_WRITE_COL, COLS, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_READ_COL, 255, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_READ_COL, 8, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_READ_COL, COLS - 1, 0, 0, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 0, 5, ROWS - 1, 0, 1, 0, 3, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 5, 0, 0, 1, 0, 0, 1, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 1, 2, 3, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 1, 2, 3, 0, 0, 0, 2, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 1, 2, 200, 0, 0, 0, 3, '0));
    pending_items.push_back(make_item(OP_ACTIVATE, 7, 7, 0, 0, 1, 1, 3, '0));
    pending_items.push_back(make_item(OP_MULTI_WRITE, 200, 200, 200, 0, 0, 0, 0, '0));
    pending_items.push_back(make_item(OP_MULTI_WRITE, 9, 255, 0, 1, 0, 0, 1, '0));
    pending_items.push_back(make_item(OP_MULTI_WRITE, 10, 10, 11, 0, 1, 1, 3, '0));
    pending_items.push_back(make_item(OP_MULTI_WRITE, 10, 11, ROWS, 0, 0, 0, 3, '0));
    pending_items.push_back(make_item(OP_SET_COL, 0, 0, 0, 0, 0, 0, 0, '0));

    for (int n = 0; n < N_RANDOM; n++) pending_items.push_back(make_random_item());

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() > 0 || beats_issued != beats_in || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
